// ===== sv/mep_pkg.sv =====
// shared types and constants of the mandelbrot escape-time pixel core
`timescale 1ns / 1ps

package mep_pkg;

    // field widths
    localparam int COL_W      = 9;
    localparam int ROW_W      = 7;
    localparam int COLOR_W    = 3;
    localparam int IN_W       = 16;

    // coordinate formats: signed Q4.28 and unsigned steps
    localparam int Q_W        = 32;
    localparam int STEP_W     = 31;
    localparam int FRAC_W     = 28;
    localparam int PRE_W      = COL_W + STEP_W;
    localparam int PIM_W      = ROW_W + STEP_W;
    localparam int SUM_W      = PRE_W + 2;

    // iteration datapath
    localparam int Z_W        = 33;
    localparam int MAG_W      = 32;
    localparam int MUL_W      = 2 * MAG_W;
    localparam int SQ_W       = MUL_W - FRAC_W;
    localparam int ACC_W      = SQ_W + 2;
    localparam logic [SQ_W:0] ESC_LIMIT = (SQ_W + 1)'(64'd1 << (FRAC_W + 2));

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RE_MIN  = 2'd0,
        CFG_RE_STEP = 2'd1,
        CFG_IM_MAX  = 2'd2,
        CFG_IM_STEP = 2'd3
    } cfg_reg_t;

    localparam logic [Q_W-1:0]    RE_MIN_RST  = 32'hD800_0000;
    localparam logic [STEP_W-1:0] RE_STEP_RST = 31'd4194304;
    localparam logic [Q_W-1:0]    IM_MAX_RST  = 32'd348966093;
    localparam logic [STEP_W-1:0] IM_STEP_RST = 31'd11078306;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [COL_W-1:0]     col;
        logic [ROW_W-1:0]     row;
        logic signed [Q_W-1:0] cr;
        logic signed [Q_W-1:0] ci;
    } job_t;

    typedef enum logic [COLOR_W-1:0] {
        COLOR_FAST   = 3'd0,
        COLOR_INSIDE = 3'd1,
        COLOR_BAND2  = 3'd2,
        COLOR_BAND3  = 3'd3,
        COLOR_BAND4  = 3'd4,
        COLOR_BAND5  = 3'd5
    } color_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_STEP,
        BK_HOLD
    } bk_state_t;

endpackage

// ===== sv/mep_front.sv =====
// front end: window registers, pixel to c mapping, hand-off into the job queue
`timescale 1ns / 1ps

module mep_front #(
    parameter int MAX_COLUMNS = 512,
    parameter int MAX_ROWS    = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mep_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [mep_pkg::COL_W-1:0]      pixel_col,
    input  logic [mep_pkg::ROW_W-1:0]      pixel_row,
    output logic                           push,
    input  logic                           q_full,
    output mep_pkg::job_t                  job
);

    localparam int COL_MAXV = (1 << mep_pkg::COL_W) - 1;
    localparam int ROW_MAXV = (1 << mep_pkg::ROW_W) - 1;
    localparam int COL_CAP  = (MAX_COLUMNS - 1 < COL_MAXV) ? MAX_COLUMNS - 1 : COL_MAXV;
    localparam int ROW_CAP  = (MAX_ROWS - 1 < ROW_MAXV) ? MAX_ROWS - 1 : ROW_MAXV;
    localparam logic [mep_pkg::COL_W-1:0] COL_LAST = mep_pkg::COL_W'(COL_CAP);
    localparam logic [mep_pkg::ROW_W-1:0] ROW_LAST = mep_pkg::ROW_W'(ROW_CAP);
    localparam int SAT_HI = mep_pkg::SUM_W - mep_pkg::Q_W;

    logic [mep_pkg::Q_W-1:0]    re_min_reg;
    logic [mep_pkg::STEP_W-1:0] re_step_reg;
    logic [mep_pkg::Q_W-1:0]    im_max_reg;
    logic [mep_pkg::STEP_W-1:0] im_step_reg;

    logic                       v1_reg, v1_next;
    logic [mep_pkg::COL_W-1:0]  col_reg;
    logic [mep_pkg::ROW_W-1:0]  row_reg;
    logic [mep_pkg::PRE_W-1:0]  prod_re_reg, prod_re_next;
    logic [mep_pkg::PIM_W-1:0]  prod_im_reg, prod_im_next;
    logic [mep_pkg::COL_W-1:0]  col_map;
    logic [mep_pkg::ROW_W-1:0]  row_map;
    logic [mep_pkg::SUM_W-1:0]  sum_re;
    logic [mep_pkg::SUM_W-1:0]  sum_im;
    logic                       take;

    function automatic logic [mep_pkg::Q_W-1:0] sat_q(input logic [mep_pkg::SUM_W-1:0] v);
        logic [SAT_HI:0] top;
        top = v[mep_pkg::SUM_W-1:mep_pkg::Q_W-1];
        if ((&top) || !(|top))
            sat_q = v[mep_pkg::Q_W-1:0];
        else if (v[mep_pkg::SUM_W-1])
            sat_q = {1'b1, {(mep_pkg::Q_W-1){1'b0}}};
        else
            sat_q = {1'b0, {(mep_pkg::Q_W-1){1'b1}}};
    endfunction

    // window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            re_min_reg  <= mep_pkg::RE_MIN_RST;
            re_step_reg <= mep_pkg::RE_STEP_RST;
            im_max_reg  <= mep_pkg::IM_MAX_RST;
            im_step_reg <= mep_pkg::IM_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (mep_pkg::cfg_reg_t'(cfg_index))
                mep_pkg::CFG_RE_MIN:  re_min_reg  <= cfg_data;
                mep_pkg::CFG_RE_STEP: re_step_reg <= cfg_data[mep_pkg::STEP_W-1:0];
                mep_pkg::CFG_IM_MAX:  im_max_reg  <= cfg_data;
                mep_pkg::CFG_IM_STEP: im_step_reg <= cfg_data[mep_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        push     = v1_reg && !q_full;
        in_ready = !v1_reg || push;
        take     = in_valid && in_ready;

        col_map = (pixel_col > COL_LAST) ? COL_LAST : pixel_col;
        row_map = (pixel_row > ROW_LAST) ? ROW_LAST : pixel_row;
        prod_re_next = mep_pkg::PRE_W'(col_map) * mep_pkg::PRE_W'(re_step_reg);
        prod_im_next = mep_pkg::PIM_W'(row_map) * mep_pkg::PIM_W'(im_step_reg);

        if (take)
            v1_next = 1'b1;
        else if (push)
            v1_next = 1'b0;
        else
            v1_next = v1_reg;

        // c = start plus (re) or minus (im) offset, wide sum then clamp into Q4.28
        sum_re = {{SAT_HI{re_min_reg[mep_pkg::Q_W-1]}}, re_min_reg}
               + {{(mep_pkg::SUM_W-mep_pkg::PRE_W){1'b0}}, prod_re_reg};
        sum_im = {{SAT_HI{im_max_reg[mep_pkg::Q_W-1]}}, im_max_reg}
               - {{(mep_pkg::SUM_W-mep_pkg::PIM_W){1'b0}}, prod_im_reg};

        job.col = col_reg;
        job.row = row_reg;
        job.cr  = sat_q(sum_re);
        job.ci  = sat_q(sum_im);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= v1_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            col_reg     <= pixel_col;
            row_reg     <= pixel_row;
            prod_re_reg <= prod_re_next;
            prod_im_reg <= prod_im_next;
        end
    end

endmodule

// ===== sv/mep_queue.sv =====
// two-entry job queue between front end and iteration engine
`timescale 1ns / 1ps

module mep_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mep_pkg::job_t push_job,
    input  logic          pop,
    output mep_pkg::job_t pop_job,
    output logic          full,
    output logic          empty
);

    mep_pkg::job_t                 slot_reg [mep_pkg::QUEUE_DEPTH];
    logic [mep_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mep_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mep_pkg::QCNT_W-1:0]    count_reg, count_next;

    always_comb
    begin
        full    = (count_reg == mep_pkg::QCNT_W'(mep_pkg::QUEUE_DEPTH));
        empty   = (count_reg == '0);
        pop_job = slot_reg[rd_ptr_reg];

        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== sv/mep_back.sv =====
// iteration engine: z = z*z + c sequencer, color band and output register
`timescale 1ns / 1ps

module mep_back #(
    parameter int MAX_ITERATIONS = 256,
    localparam int ITER_W = $clog2(MAX_ITERATIONS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  mep_pkg::job_t                 job,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mep_pkg::COL_W-1:0]     out_col,
    output logic [mep_pkg::ROW_W-1:0]     out_row,
    output logic [ITER_W-1:0]             out_iter,
    output logic [mep_pkg::COLOR_W-1:0]   out_color
);

    localparam int BAND_W = ITER_W + 6;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(MAX_ITERATIONS);
    localparam logic [BAND_W-1:0] FAST_LIM  = BAND_W'(MAX_ITERATIONS);
    localparam logic [BAND_W-1:0] BAND_OFS  = BAND_W'(4 * MAX_ITERATIONS);
    localparam logic [BAND_W-1:0] STEP1     = BAND_W'(9 * MAX_ITERATIONS);
    localparam logic [BAND_W-1:0] STEP2     = BAND_W'(18 * MAX_ITERATIONS);
    localparam logic [BAND_W-1:0] STEP3     = BAND_W'(27 * MAX_ITERATIONS);

    mep_pkg::bk_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    logic signed [mep_pkg::Z_W-1:0] zr_reg, zr_next;
    logic signed [mep_pkg::Z_W-1:0] zi_reg, zi_next;
    logic [mep_pkg::Q_W-1:0]        cr_reg, cr_next;
    logic [mep_pkg::Q_W-1:0]        ci_reg, ci_next;
    logic [mep_pkg::COL_W-1:0]      col_reg, col_next;
    logic [mep_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [ITER_W-1:0]              n_reg, n_next;
    logic [ITER_W-1:0]              res_reg, res_next;
    logic [mep_pkg::SQ_W-1:0]       sq_r_reg, sq_r_next;
    logic [mep_pkg::SQ_W-1:0]       sq_i_reg, sq_i_next;
    logic [mep_pkg::SQ_W-1:0]       p_mag_reg, p_mag_next;
    logic                           p_neg_reg, p_neg_next;
    logic [mep_pkg::COL_W-1:0]      oc_reg, oc_next;
    logic [mep_pkg::ROW_W-1:0]      or_reg, or_next;
    logic [ITER_W-1:0]              oi_reg, oi_next;
    logic [mep_pkg::COLOR_W-1:0]    ok_reg, ok_next;

    logic [mep_pkg::Z_W-1:0]   zr_abs, zi_abs;
    logic [mep_pkg::MUL_W-1:0] mul_rr, mul_ii, mul_ri;
    logic [mep_pkg::SQ_W:0]    mag2;
    logic [mep_pkg::ACC_W-1:0] acc_r, acc_i, twice_p, twice_p_s;
    logic [BAND_W-1:0]         res_ext, num;
    logic [mep_pkg::COLOR_W-1:0] band;
    logic                      out_free;

    always_comb
    begin
        // magnitudes and the three products of one iteration
        zr_abs = zr_reg[mep_pkg::Z_W-1] ? (~zr_reg + 1'b1) : zr_reg;
        zi_abs = zi_reg[mep_pkg::Z_W-1] ? (~zi_reg + 1'b1) : zi_reg;
        mul_rr = mep_pkg::MUL_W'(zr_abs[mep_pkg::MAG_W-1:0])
               * mep_pkg::MUL_W'(zr_abs[mep_pkg::MAG_W-1:0]);
        mul_ii = mep_pkg::MUL_W'(zi_abs[mep_pkg::MAG_W-1:0])
               * mep_pkg::MUL_W'(zi_abs[mep_pkg::MAG_W-1:0]);
        mul_ri = mep_pkg::MUL_W'(zr_abs[mep_pkg::MAG_W-1:0])
               * mep_pkg::MUL_W'(zi_abs[mep_pkg::MAG_W-1:0]);

        // |z|^2 of the current z and the update from the registered products
        mag2      = {1'b0, sq_r_reg} + {1'b0, sq_i_reg};
        acc_r     = {2'b00, sq_r_reg} - {2'b00, sq_i_reg}
                  + {{(mep_pkg::ACC_W-mep_pkg::Q_W){cr_reg[mep_pkg::Q_W-1]}}, cr_reg};
        twice_p   = {1'b0, p_mag_reg, 1'b0};
        twice_p_s = p_neg_reg ? (~twice_p + 1'b1) : twice_p;
        acc_i     = twice_p_s
                  + {{(mep_pkg::ACC_W-mep_pkg::Q_W){ci_reg[mep_pkg::Q_W-1]}}, ci_reg};

        // color band from the final count
        res_ext = BAND_W'(res_reg);
        num     = res_ext * BAND_W'(40) - BAND_OFS;
        if (res_reg >= ITER_LAST)
            band = mep_pkg::COLOR_INSIDE;
        else if (res_ext * BAND_W'(10) < FAST_LIM)
            band = mep_pkg::COLOR_FAST;
        else if (num >= STEP3)
            band = mep_pkg::COLOR_BAND5;
        else if (num >= STEP2)
            band = mep_pkg::COLOR_BAND4;
        else if (num >= STEP1)
            band = mep_pkg::COLOR_BAND3;
        else
            band = mep_pkg::COLOR_BAND2;

        out_free = !out_valid_reg || out_ready;

        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pop            = 1'b0;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        n_next     = n_reg;
        res_next   = res_reg;
        sq_r_next  = sq_r_reg;
        sq_i_next  = sq_i_reg;
        p_mag_next = p_mag_reg;
        p_neg_next = p_neg_reg;
        oc_next    = oc_reg;
        or_next    = or_reg;
        oi_next    = oi_reg;
        ok_next    = ok_reg;

        case (state_reg)
            mep_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    zr_next    = '0;
                    zi_next    = '0;
                    cr_next    = job.cr;
                    ci_next    = job.ci;
                    col_next   = job.col;
                    row_next   = job.row;
                    n_next     = '0;
                    state_next = mep_pkg::BK_MUL;
                end
            end
            mep_pkg::BK_MUL:
            begin
                sq_r_next  = mul_rr[mep_pkg::MUL_W-1:mep_pkg::FRAC_W];
                sq_i_next  = mul_ii[mep_pkg::MUL_W-1:mep_pkg::FRAC_W];
                p_mag_next = mul_ri[mep_pkg::MUL_W-1:mep_pkg::FRAC_W];
                p_neg_next = zr_reg[mep_pkg::Z_W-1] ^ zi_reg[mep_pkg::Z_W-1];
                state_next = mep_pkg::BK_STEP;
            end
            mep_pkg::BK_STEP:
            begin
                // escape test belongs to the update just done
                if (mag2 > mep_pkg::ESC_LIMIT)
                begin
                    res_next   = n_reg - 1'b1;
                    state_next = mep_pkg::BK_HOLD;
                end
                else if (n_reg == ITER_LAST)
                begin
                    res_next   = ITER_LAST;
                    state_next = mep_pkg::BK_HOLD;
                end
                else
                begin
                    zr_next    = acc_r[mep_pkg::Z_W-1:0];
                    zi_next    = acc_i[mep_pkg::Z_W-1:0];
                    n_next     = n_reg + 1'b1;
                    state_next = mep_pkg::BK_MUL;
                end
            end
            mep_pkg::BK_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    oc_next        = col_reg;
                    or_next        = row_reg;
                    oi_next        = res_reg;
                    ok_next        = band;
                    state_next     = mep_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = mep_pkg::BK_IDLE;
            end
        endcase

        out_valid = out_valid_reg;
        out_col   = oc_reg;
        out_row   = or_reg;
        out_iter  = oi_reg;
        out_color = ok_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mep_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        cr_reg    <= cr_next;
        ci_reg    <= ci_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        n_reg     <= n_next;
        res_reg   <= res_next;
        sq_r_reg  <= sq_r_next;
        sq_i_reg  <= sq_i_next;
        p_mag_reg <= p_mag_next;
        p_neg_reg <= p_neg_next;
        oc_reg    <= oc_next;
        or_reg    <= or_next;
        oi_reg    <= oi_next;
        ok_reg    <= ok_next;
    end

endmodule

// ===== sv/mandelbrot_escape_time_pixel_core.sv =====
// top level of the mandelbrot escape-time pixel core
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  pixel_col, pixel_row
// m_*       out  m_tvalid/m_tready  out_col, out_row, iter_count, color_code
// cfg_*     in   cfg_we             re_min, re_step, im_max, im_step by index
//
// the engine iterates a pixel until it escapes or reaches MAX_ITERATIONS;
// each iteration is a multiply state (BK_MUL, three 32x32 products) and an
// add/test state (BK_STEP)
// reset clears handshake state and loads the default viewing window
// the front end and a two-entry queue take up to three pixels ahead of the
// engine; a stalled result output only holds the engine once it finishes

module mandelbrot_escape_time_pixel_core #(
    parameter int MAX_ITERATIONS = 256,
    parameter int MAX_COLUMNS    = 512,
    parameter int MAX_ROWS       = 128,
    localparam int ITER_W = $clog2(MAX_ITERATIONS + 1),
    localparam int OUT_FW = mep_pkg::COL_W + mep_pkg::ROW_W + ITER_W + mep_pkg::COLOR_W,
    localparam int OUT_W  = ((OUT_FW + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // pixel input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pixel_col [8:0], pixel_row [15:9]
    input  logic [mep_pkg::IN_W-1:0]       s_tdata,
    // result output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_col, out_row, iter_count, color_code from bit 0 up, zero padded
    output logic [OUT_W-1:0]               m_tdata,
    // window register writes
    input  logic                           cfg_we,
    input  logic [mep_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(MAX_ITERATIONS);

    // front to queue
    mep_pkg::job_t push_job;
    logic          q_push;
    logic          q_full;

    // queue to engine
    mep_pkg::job_t pop_job;
    logic          q_pop;
    logic          q_empty;

    // engine result fields
    logic [mep_pkg::COL_W-1:0]   out_col;
    logic [mep_pkg::ROW_W-1:0]   out_row;
    logic [ITER_W-1:0]           out_iter;
    logic [mep_pkg::COLOR_W-1:0] out_color;

    // maps the pixel to c and hands it on
    mep_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .pixel_col (s_tdata[mep_pkg::COL_W-1:0]),
        .pixel_row (s_tdata[mep_pkg::COL_W +: mep_pkg::ROW_W]),
        .push      (q_push),
        .q_full    (q_full),
        .job       (push_job)
    );

    // decouples mapping from iteration
    mep_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    // iterates one pixel at a time, result sits in its output register
    mep_back #(
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .job       (pop_job),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_col   (out_col),
        .out_row   (out_row),
        .out_iter  (out_iter),
        .out_color (out_color)
    );

    assign m_tdata = OUT_W'({out_color, out_iter, out_row, out_col});

    // queue is never written while full
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("job pushed into full queue");

    // engine never takes a job that is not there
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("job popped from empty queue");

    // inside band goes with a count that never escaped, and only with it
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((out_iter == ITER_LAST) == (out_color == mep_pkg::COLOR_INSIDE)))
        else $error("color band disagrees with iteration count");

endmodule
